// ===== design/rpn_pkg.sv =====
package rpn_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int DATA_W      = 32;
	localparam int TOKEN_W     = 8;

	localparam logic [TOKEN_W-1:0] CH_ADD  = 8'd43;
	localparam logic [TOKEN_W-1:0] CH_SUB  = 8'd45;
	localparam logic [TOKEN_W-1:0] CH_MUL  = 8'd42;
	localparam logic [TOKEN_W-1:0] CH_DIV  = 8'd47;
	localparam logic [DATA_W-1:0]  CH_ZERO = 32'd48;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_UNDER    = 3'd1,
		ST_LEFTOVER = 3'd2,
		ST_OVER     = 3'd3,
		ST_DIVZERO  = 3'd4
	} status_t;

endpackage

// ===== design/rpn_tok_if.sv =====
interface rpn_tok_if import rpn_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [TOKEN_W-1:0] token;
	logic               last;

	modport source (output valid, token, last, input ready);
	modport sink   (input valid, token, last, output ready);
endinterface

// ===== design/rpn_res_if.sv =====
interface rpn_res_if import rpn_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] value;
	status_t                  status;

	modport source (output valid, value, status, input ready);
	modport sink   (input valid, value, status, output ready);
endinterface

// ===== design/rpn_expression_evaluator_unit.sv =====
// RPN expression evaluator.
// Channel tokens (sink): one character per transfer, last marks the end of the
// expression. Operators + - * / take two operands off the stack and push the
// result; any other byte pushes its code minus 48. Channel results (source):
// one transfer per expression, value and status (0 ok, 1 underflow,
// 2 leftover operands, 3 overflow, 4 divide by zero); value is 0 on error.
// The operand stack lives in a single-port-read, single-port-write RAM with a
// registered read; operands are fetched one per cycle.
// Operators pass through operand fetch, the ALU and write-back; divide first
// runs in the bit-serial restoring divider, and the last token of an expression
// then fetches the answer and loads the result register.
// Once an error is flagged the rest of the expression's tokens leave the stack alone.
// Only one token is in work at a time; tokens.ready is high when idle.
// The result register holds while results.ready is low; the next expression
// can be taken in meanwhile, and only its last token waits for the register.
// Reset clears the stack count, the error and the result valid; stack contents
// need no clearing.
module rpn_expression_evaluator_unit import rpn_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	rpn_tok_if.sink tokens,
	rpn_res_if.source results
);

	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_RD2, S_OPS, S_ALU, S_DIV, S_DSGN, S_WB, S_END, S_FIN
	} state_t;

	state_t              state_q;
	logic [TOKEN_W-1:0]  tok_q;
	logic                last_q;
	logic [CNT_W-1:0]    cnt_q;
	status_t             err_q;
	logic [DATA_W-1:0]   rhs_q;
	logic [DATA_W-1:0]   lhs_q;
	logic [DATA_W-1:0]   res_q;
	logic [DATA_W-1:0]   quo_q;
	logic [DATA_W-1:0]   den_q;
	logic [DATA_W-1:0]   rem_q;
	logic [4:0]          dcnt_q;
	logic                neg_q;
	logic                out_valid_q;
	logic [DATA_W-1:0]   out_value_q;
	status_t             out_status_q;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [DATA_W-1:0]   ram_wdata;
	logic                ram_re;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [DATA_W-1:0]   ram_rdata;

	logic                is_op;
	logic                can_pop;
	logic                can_push;
	logic [DATA_W-1:0]   push_val;
	logic [DATA_W:0]     rem_sh;
	logic [DATA_W:0]     rem_diff;
	logic [DATA_W-1:0]   mag_l;
	logic [DATA_W-1:0]   mag_r;
	status_t             fin_status;
	logic                out_free;

	assign is_op    = (tok_q == CH_ADD) || (tok_q == CH_SUB) ||
	                  (tok_q == CH_MUL) || (tok_q == CH_DIV);
	assign can_pop  = cnt_q >= CNT_W'(2);
	assign can_push = cnt_q < CNT_W'(STACK_DEPTH);
	assign push_val = {{(DATA_W-TOKEN_W){1'b0}}, tok_q} - CH_ZERO;

	assign mag_l = lhs_q[DATA_W-1] ? (DATA_W'(0) - lhs_q) : lhs_q;
	assign mag_r = rhs_q[DATA_W-1] ? (DATA_W'(0) - rhs_q) : rhs_q;

	// restoring step: shift in next dividend bit, try to subtract divisor
	assign rem_sh   = {rem_q, quo_q[DATA_W-1]};
	assign rem_diff = rem_sh - {1'b0, den_q};

	always_comb begin
		if (err_q != ST_OK) begin
			fin_status = err_q;
		end else if (cnt_q == CNT_W'(0)) begin
			fin_status = ST_UNDER;
		end else if (cnt_q != CNT_W'(1)) begin
			fin_status = ST_LEFTOVER;
		end else begin
			fin_status = ST_OK;
		end
	end

	assign out_free = !out_valid_q || results.ready;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = push_val;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			S_DEC: begin
				if (err_q == ST_OK) begin
					if (is_op && can_pop) begin
						ram_re    = 1'b1;
						ram_raddr = ADDR_W'(cnt_q - CNT_W'(1));
					end else if (!is_op && can_push) begin
						ram_we    = 1'b1;
						ram_waddr = ADDR_W'(cnt_q);
					end
				end
			end
			S_RD2: begin
				ram_re    = 1'b1;
				ram_raddr = ADDR_W'(cnt_q - CNT_W'(2));
			end
			S_WB: begin
				ram_we    = 1'b1;
				ram_waddr = ADDR_W'(cnt_q - CNT_W'(2));
				ram_wdata = res_q;
			end
			S_END: begin
				// answer sits at the bottom when exactly one operand is left
				ram_re    = 1'b1;
				ram_raddr = '0;
			end
			default: begin
			end
		endcase
	end

	rpn_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			tok_q        <= '0;
			last_q       <= 1'b0;
			cnt_q        <= '0;
			err_q        <= ST_OK;
			rhs_q        <= '0;
			lhs_q        <= '0;
			res_q        <= '0;
			quo_q        <= '0;
			den_q        <= '0;
			rem_q        <= '0;
			dcnt_q       <= '0;
			neg_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			out_value_q  <= '0;
			out_status_q <= ST_OK;
		end else begin
			// S_FIN loads the register itself when it is drained
			if (out_valid_q && results.ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (tokens.valid) begin
						tok_q   <= tokens.token;
						last_q  <= tokens.last;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					state_q <= S_END;
					if (err_q == ST_OK) begin
						if (is_op) begin
							if (can_pop) begin
								state_q <= S_RD2;
							end else begin
								err_q <= ST_UNDER;
							end
						end else if (can_push) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end else begin
							err_q <= ST_OVER;
						end
					end
				end
				S_RD2: begin
					rhs_q   <= ram_rdata;
					state_q <= S_OPS;
				end
				S_OPS: begin
					lhs_q   <= ram_rdata;
					state_q <= S_ALU;
				end
				S_ALU: begin
					state_q <= S_WB;
					if (tok_q == CH_ADD) begin
						res_q <= lhs_q + rhs_q;
					end else if (tok_q == CH_SUB) begin
						res_q <= lhs_q - rhs_q;
					end else if (tok_q == CH_MUL) begin
						res_q <= DATA_W'(lhs_q * rhs_q);
					end else if (rhs_q == '0) begin
						err_q   <= ST_DIVZERO;
						state_q <= S_END;
					end else begin
						quo_q   <= mag_l;
						den_q   <= mag_r;
						rem_q   <= '0;
						neg_q   <= lhs_q[DATA_W-1] ^ rhs_q[DATA_W-1];
						dcnt_q  <= 5'd31;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (!rem_diff[DATA_W]) begin
						rem_q <= rem_diff[DATA_W-1:0];
						quo_q <= {quo_q[DATA_W-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh[DATA_W-1:0];
						quo_q <= {quo_q[DATA_W-2:0], 1'b0};
					end
					dcnt_q <= dcnt_q - 5'd1;
					if (dcnt_q == 5'd0) begin
						state_q <= S_DSGN;
					end
				end
				S_DSGN: begin
					res_q   <= neg_q ? (DATA_W'(0) - quo_q) : quo_q;
					state_q <= S_WB;
				end
				S_WB: begin
					cnt_q   <= cnt_q - CNT_W'(1);
					state_q <= S_END;
				end
				S_END: begin
					state_q <= last_q ? S_FIN : S_IDLE;
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= fin_status;
						out_value_q  <= (fin_status == ST_OK) ? ram_rdata : '0;
						cnt_q        <= '0;
						err_q        <= ST_OK;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign tokens.ready   = (state_q == S_IDLE);
	assign results.valid  = out_valid_q;
	assign results.value  = out_value_q;
	assign results.status = out_status_q;

endmodule

// ===== design/rpn_ram.sv =====
module rpn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/rpn_checker.sv =====
module rpn_checker import rpn_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [DATA_W-1:0] out_value,
	input logic [2:0]        out_status
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status))
		else $error("result changed while stalled");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_status <= 3'(ST_DIVZERO))
		else $error("status code out of range");

	a_err_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != 3'(ST_OK) |-> out_value == '0)
		else $error("nonzero value with error status");

	// one token in work at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("token taken while previous still in work");

endmodule

bind rpn_expression_evaluator_unit rpn_checker u_rpn_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (tokens.valid),
	.in_ready  (tokens.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_value (results.value),
	.out_status(results.status)
);

// ===== tb/rpn_expression_evaluator_unit_test.sv =====
`timescale 1ns / 1ps

import rpn_pkg::*;

typedef struct packed {
	logic signed [DATA_W-1:0] value;
	status_t                  status;
} rpn_answer_t;

function automatic bit is_operator(logic [TOKEN_W-1:0] tok);
	return tok == CH_ADD || tok == CH_SUB || tok == CH_MUL || tok == CH_DIV;
endfunction

class rpn_scoreboard;
	logic [DATA_W-1:0] operands [STACK_DEPTH];
	int unsigned       depth;
	status_t           fault;
	rpn_answer_t       pending [$];
	int unsigned       fails;

	function new();
		depth = 0;
		fault = ST_OK;
		fails = 0;
	endfunction

	task report(string msg);
		fails++;
		$display("[%0t] MISMATCH %s", $time, msg);
	endtask

	// Returns 1 when the token acted on the stack (not swallowed by an earlier error).
	function bit note_token(logic [TOKEN_W-1:0] tok, logic fin);
		logic [DATA_W-1:0] lhs, rhs, res, mag_l, mag_r, quo;
		rpn_answer_t       ans;
		bit                acted;
		acted = (fault == ST_OK);
		if (acted) begin
			if (is_operator(tok)) begin
				if (depth < 2) begin
					fault = ST_UNDER;
				end else begin
					rhs = operands[depth-1];
					lhs = operands[depth-2];
					res = '0;
					case (tok)
						CH_ADD: res = lhs + rhs;
						CH_SUB: res = lhs - rhs;
						CH_MUL: res = lhs * rhs;
						default: begin
							if (rhs == '0) begin
								fault = ST_DIVZERO;
							end else begin
								// truncating divide on magnitudes; MIN / -1 wraps back to MIN
								mag_l = lhs[DATA_W-1] ? -lhs : lhs;
								mag_r = rhs[DATA_W-1] ? -rhs : rhs;
								quo = mag_l / mag_r;
								res = (lhs[DATA_W-1] ^ rhs[DATA_W-1]) ? -quo : quo;
							end
						end
					endcase
					if (fault == ST_OK) begin
						depth--;
						operands[depth-1] = res;
					end
				end
			end else if (depth >= STACK_DEPTH) begin
				fault = ST_OVER;
			end else begin
				operands[depth] = {{(DATA_W-TOKEN_W){1'b0}}, tok} - CH_ZERO;
				depth++;
			end
		end
		if (fin) begin
			ans.value = '0;
			if (fault != ST_OK) begin
				ans.status = fault;
			end else if (depth == 0) begin
				ans.status = ST_UNDER;
			end else if (depth > 1) begin
				ans.status = ST_LEFTOVER;
			end else begin
				ans.status = ST_OK;
				ans.value  = operands[0];
			end
			pending.push_back(ans);
			depth = 0;
			fault = ST_OK;
		end
		return acted;
	endfunction

	task check_result(logic signed [DATA_W-1:0] value, status_t status);
		rpn_answer_t want;
		if (pending.size() == 0) begin
			report($sformatf("result with nothing outstanding: value %0d status %0d",
				value, status));
			return;
		end
		want = pending.pop_front();
		if (status !== want.status)
			report($sformatf("status %0d, wanted %0d", status, want.status));
		if (value !== want.value)
			report($sformatf("value %0d, wanted %0d", value, want.value));
	endtask
endclass

module rpn_expression_evaluator_unit_test;

	typedef enum {EXPR_OVERFLOW, EXPR_FULL, EXPR_CLEAN, EXPR_BROKEN, EXPR_NOISE} expr_kind_t;

	logic clk;
	logic arst_n;

	rpn_tok_if tok_ch ();
	rpn_res_if res_ch ();

	rpn_expression_evaluator_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.tokens  (tok_ch),
		.results (res_ch)
	);

	rpn_scoreboard      sb;
	logic [TOKEN_W-1:0] expr_q [$];
	int unsigned        live_tokens;
	bit                 tok_calm;
	bit                 res_calm;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_200_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int pick_gap(inout bit calm);
		if ($urandom_range(0, 15) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 14);
	endfunction

	function automatic logic [TOKEN_W-1:0] dig(int n);
		return TOKEN_W'(CH_ZERO + n);
	endfunction

	function automatic logic [TOKEN_W-1:0] rand_operand();
		logic [TOKEN_W-1:0] t;
		if ($urandom_range(0, 9) < 7)
			return dig($urandom_range(0, 9));
		do
			t = TOKEN_W'($urandom_range(0, 255));
		while (is_operator(t));
		return t;
	endfunction

	function automatic logic [TOKEN_W-1:0] rand_operator();
		case ($urandom_range(0, 3))
			0: return CH_ADD;
			1: return CH_SUB;
			2: return CH_MUL;
			default: return CH_DIV;
		endcase
	endfunction

	// Called at a falling edge, returns at a falling edge.
	task automatic send_token(logic [TOKEN_W-1:0] tok, logic fin);
		int gap;
		gap = pick_gap(tok_calm);
		if (gap > 0) begin
			tok_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		tok_ch.valid <= 1'b1;
		tok_ch.token <= tok;
		tok_ch.last  <= fin;
		do
			@(posedge clk);
		while (!tok_ch.ready);
		if (sb.note_token(tok, fin))
			live_tokens++;
		@(negedge clk);
	endtask

	task automatic send_expr(logic [TOKEN_W-1:0] toks [$]);
		foreach (toks[i])
			send_token(toks[i], i == toks.size() - 1);
	endtask

	// Well-formed postfix with n operands; operators come in at random once two are held.
	task automatic build_clean(int n);
		int held, pushed;
		expr_q.delete();
		held   = 0;
		pushed = 0;
		while (pushed < n || held > 1) begin
			if (pushed < n && (held < 2 || $urandom_range(0, 1))) begin
				expr_q.push_back(rand_operand());
				held++;
				pushed++;
			end else begin
				expr_q.push_back(rand_operator());
				held--;
			end
		end
	endtask

	initial begin
		tok_ch.valid = 1'b0;
		tok_ch.token = '0;
		tok_ch.last  = 1'b0;
		res_ch.ready = 1'b0;
		arst_n       = 1'b0;
		live_tokens  = 0;
		tok_calm     = 1'b0;
		res_calm     = 1'b0;
		sb = new();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
	end

	// Result side: a random stall per transfer.
	initial begin
		int stall;
		wait (arst_n);
		forever begin
			@(negedge clk);
			stall = pick_gap(res_calm);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!res_ch.valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_result(res_ch.value, res_ch.status);
	end

	initial begin
		expr_kind_t kind;
		int         n_expr, r, n;
		wait (arst_n);
		@(negedge clk);

		// extreme bytes, multiply, truncating divide of a negative
		send_expr('{8'hFF, 8'h00, CH_MUL, dig(7), CH_DIV});
		send_expr('{dig(9), dig(3), CH_SUB, dig(1), CH_ADD});
		send_expr('{dig(5), dig(0), CH_DIV});
		send_expr('{dig(1), dig(2)});
		// underflow, and the push after it must be ignored
		send_expr('{CH_ADD, dig(1)});
		// 2^31 wraps to the most negative value, then divide by -1
		send_expr('{dig(128), dig(128), CH_MUL, dig(128), CH_MUL, dig(128), CH_MUL,
			dig(8), CH_MUL, dig(0), dig(1), CH_SUB, CH_DIV});

		live_tokens = 0;
		n_expr      = 0;
		while (live_tokens < 1450) begin
			r = $urandom_range(0, 99);
			if (n_expr == 0 || r < 2)
				kind = EXPR_OVERFLOW;
			else if (n_expr == 1 || r < 3)
				kind = EXPR_FULL;
			else if (r < 70)
				kind = EXPR_CLEAN;
			else if (r < 85)
				kind = EXPR_BROKEN;
			else
				kind = EXPR_NOISE;
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
			case (kind)
				EXPR_OVERFLOW: begin
					expr_q.delete();
					repeat (STACK_DEPTH + 1 + $urandom_range(0, 3))
						expr_q.push_back(rand_operand());
					repeat ($urandom_range(0, 2))
						expr_q.push_back(rand_operator());
				end
				EXPR_FULL: begin
					// fill to the brim without tipping over; no divide so it mostly ends ok
					expr_q.delete();
					repeat (STACK_DEPTH)
						expr_q.push_back(rand_operand());
					repeat (STACK_DEPTH - 1)
						case ($urandom_range(0, 2))
							0: expr_q.push_back(CH_ADD);
							1: expr_q.push_back(CH_SUB);
							default: expr_q.push_back(CH_MUL);
						endcase
				end
				EXPR_CLEAN: build_clean(n);
				EXPR_BROKEN: begin
					build_clean(n);
					expr_q.insert($urandom_range(0, expr_q.size()),
						$urandom_range(0, 1) ? rand_operand() : rand_operator());
				end
				default: begin
					expr_q.delete();
					repeat ($urandom_range(1, 10))
						expr_q.push_back($urandom_range(0, 1) ? rand_operator()
							: TOKEN_W'($urandom_range(0, 255)));
				end
			endcase
			send_expr(expr_q);
			n_expr++;
		end
		tok_ch.valid <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (sb.fails == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
